FILE: design/grdda_pkg.sv
package grdda_pkg;

    localparam int MAP_SIZE  = 32;
    localparam int MAP_BITS  = 5;
    localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
    localparam int TEX_BITS  = 6;
    localparam int MAX_STEPS = 64;
    localparam int STEP_BITS = 7;
    localparam logic [25:0] PERP_MAX = 26'h3FFFFFF;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    localparam logic CFG_PASSABLE = 1'b0;
    localparam logic CFG_MIN_DIST = 1'b1;

    typedef struct packed {
        logic       start;
        logic       neg;
        logic [47:0] num;
        logic [17:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] quot;
    } t_div_rsp;

endpackage

FILE: design/grdda_div.sv
module grdda_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  grdda_pkg::t_div_req i_req,
    output grdda_pkg::t_div_rsp o_rsp
);

    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [47:0] r_q, n_q;
    logic [17:0] r_rem, n_rem;
    logic [17:0] r_den, n_den;
    logic [18:0] w_trial;

    assign w_trial = {r_rem, r_q[47]} - {1'b0, r_den};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_q    = i_req.num;
            n_rem  = 18'd0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (!w_trial[18]) begin
                n_rem = w_trial[17:0];
                n_q   = {r_q[46:0], 1'b1};
            end else begin
                n_rem = {r_rem[16:0], r_q[47]};
                n_q   = {r_q[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: design/grid_ray_cast_dda.sv
// a write word stores its cell value and gives no result word; a cast walks up to 64 dda
// steps through the map, then divides for the perpendicular distance when a wall is hit
// a ray that leaves the map gives its no_hit word without a divide
// throughput: one word at a time, no word is taken until the previous result is handed off
// reset: synchronous active low; a clearing pass wipes all 1024 map cells first,
// during which no word is accepted; registers return to passable 11, min distance 655
module grid_ray_cast_dda (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // cell_x, cell_y, cell_value, pos_x, pos_y, dir_x, dir_y, step_x, step_y
    input  logic [151:0] i_s_tdata,
    // kind
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // hit_x, hit_y, side, perp_dist, wall_frac, tex_col, tex_index, floor_x, floor_y
    output logic [111:0] o_m_tdata,
    // no_hit
    output logic        o_m_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_MULX = 4'd2;
    localparam logic [3:0] ST_MULY = 4'd3;
    localparam logic [3:0] ST_STEP = 4'd4;
    localparam logic [3:0] ST_LOOK = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_DWT  = 4'd7;
    localparam logic [3:0] ST_WALL = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;
    localparam logic [3:0] ST_RD   = 4'd11;

    logic [3:0]  r_st;
    logic [9:0]  r_clr;
    logic [7:0]  r_pass;
    logic [15:0] r_mind;
    logic [7:0]  r_mem [grdda_pkg::MAP_CELLS];
    logic [7:0]  r_rd;

    logic signed [6:0]  r_mx, r_my;
    logic [20:0] r_px, r_py;
    logic signed [17:0] r_dx, r_dy;
    logic [25:0] r_sx, r_sy;
    logic [33:0] r_distx, r_disty;
    logic        r_side;
    logic [6:0]  r_steps;
    logic [25:0] r_perp;
    logic [15:0] r_frac;
    logic [7:0]  r_code;
    logic        r_ovf;
    logic        r_mvalid;
    logic [111:0] r_mdata;
    logic        r_muser;

    logic signed [22:0] r_ma;
    logic signed [26:0] r_mb;
    logic signed [49:0] w_prod;
    assign w_prod = r_ma * r_mb;

    grdda_pkg::t_div_req w_req;
    grdda_pkg::t_div_rsp w_rsp;
    grdda_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic w_acc;
    assign o_s_tready = (r_st == ST_IDLE) && !r_mvalid;
    assign w_acc = i_s_tvalid && o_s_tready;

    logic [4:0]  w_cx, w_cy;
    logic [7:0]  w_cv;
    logic [20:0] w_px, w_py;
    logic [17:0] w_dx, w_dy;
    logic [25:0] w_sx, w_sy;
    assign w_cx = i_s_tdata[4:0];
    assign w_cy = i_s_tdata[9:5];
    assign w_cv = i_s_tdata[17:10];
    assign w_px = i_s_tdata[38:18];
    assign w_py = i_s_tdata[59:39];
    assign w_dx = i_s_tdata[77:60];
    assign w_dy = i_s_tdata[95:78];
    assign w_sx = i_s_tdata[121:96];
    assign w_sy = i_s_tdata[147:122];

    // division operands
    logic signed [23:0] w_num;
    logic signed [17:0] w_den;
    logic               w_neg;
    logic [23:0]        w_anum;
    logic [17:0]        w_aden;
    always_comb begin
        if (!r_side) begin
            w_num = $signed({1'b0, r_mx[4:0], 16'd0}) - $signed({1'b0, r_px})
                    + (r_dx < 0 ? 24'sd65536 : 24'sd0);
            w_den = r_dx;
        end else begin
            w_num = $signed({1'b0, r_my[4:0], 16'd0}) - $signed({1'b0, r_py})
                    + (r_dy < 0 ? 24'sd65536 : 24'sd0);
            w_den = r_dy;
        end
        w_neg  = w_num[23] ^ w_den[17];
        w_anum = w_num[23] ? -w_num : w_num;
        w_aden = w_den[17] ? -w_den : w_den;
        w_req.start = (r_st == ST_DIV);
        w_req.neg   = w_neg;
        w_req.num   = {w_anum, 24'd0} >> 8;
        w_req.den   = w_aden;
    end

    logic r_qneg;
    logic [25:0] w_perpc;
    always_comb begin
        if (w_rsp.quot == 48'd0) w_perpc = 26'd0;
        else if (r_qneg) w_perpc = 26'd0;
        else if (|w_rsp.quot[47:26]) w_perpc = grdda_pkg::PERP_MAX;
        else w_perpc = w_rsp.quot[25:0];
    end

    logic signed [6:0] n_mx, n_my;
    assign n_mx = r_mx + (r_dx[17] ? -7'sd1 : 7'sd1);
    assign n_my = r_my + (r_dy[17] ? -7'sd1 : 7'sd1);
    logic [9:0] w_addr;
    assign w_addr = {r_mx[4:0], r_my[4:0]};

    logic signed [49:0] w_fl;
    assign w_fl = w_prod >>> 16;

    logic [5:0]  w_tcol;
    logic [21:0] w_fx, w_fy;
    logic [25:0] w_pb;
    logic [26:0] w_psum;
    always_comb begin
        w_tcol = r_frac[15:10];
        if ((!r_side && r_dx > 0) || (r_side && r_dy < 0)) w_tcol = ~w_tcol;
        w_fx = {1'b0, r_mx[4:0], r_frac};
        w_fy = {1'b0, r_my[4:0], 16'd0} + 22'd65536;
        if (!r_side && r_dx > 0) begin
            w_fx = {1'b0, r_mx[4:0], 16'd0};
            w_fy = {1'b0, r_my[4:0], r_frac};
        end else if (!r_side && r_dx < 0) begin
            w_fx = {1'b0, r_mx[4:0], 16'd0} + 22'd65536;
            w_fy = {1'b0, r_my[4:0], r_frac};
        end else if (r_side && r_dy > 0) begin
            w_fx = {1'b0, r_mx[4:0], r_frac};
            w_fy = {1'b0, r_my[4:0], 16'd0};
        end
        w_psum = {1'b0, r_perp} + {11'd0, r_mind};
        w_pb = r_perp;
        if (r_perp < {10'd0, r_mind}) w_pb = w_psum[26] ? grdda_pkg::PERP_MAX : w_psum[25:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_CLR;
            r_clr    <= 10'd0;
            r_pass   <= 8'd11;
            r_mind   <= 16'd655;
            r_mvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == grdda_pkg::CFG_PASSABLE) r_pass <= i_cfg_data[7:0];
                else r_mind <= i_cfg_data;
            end
            if (r_mvalid && i_m_tready) r_mvalid <= 1'b0;
            case (r_st)
                ST_CLR: begin
                    r_mem[r_clr] <= 8'd0;
                    r_clr <= r_clr + 10'd1;
                    if (r_clr == 10'd1023) r_st <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_s_tuser == grdda_pkg::KIND_WRITE) begin
                            r_mem[{w_cx, w_cy}] <= w_cv;
                        end else begin
                            r_mx <= {2'b00, w_cx};
                            r_my <= {2'b00, w_cy};
                            r_px <= w_px; r_py <= w_py;
                            r_dx <= w_dx; r_dy <= w_dy;
                            r_sx <= w_sx; r_sy <= w_sy;
                            r_steps <= 7'd0;
                            r_ma <= w_dx[17] ? $signed({1'b0, w_px}) - $signed({1'b0, w_cx, 16'd0})
                                : $signed({1'b0, w_cx, 16'd0}) + 23'sd65536 - $signed({1'b0, w_px});
                            r_mb <= $signed({1'b0, w_sx});
                            r_st <= ST_MULX;
                        end
                    end
                end
                ST_MULX: begin
                    r_distx <= w_fl[33:0];
                    r_ma <= r_dy[17] ? $signed({1'b0, r_py}) - $signed({1'b0, r_my[4:0], 16'd0})
                        : $signed({1'b0, r_my[4:0], 16'd0}) + 23'sd65536 - $signed({1'b0, r_py});
                    r_mb <= $signed({1'b0, r_sy});
                    r_st <= ST_MULY;
                end
                ST_MULY: begin
                    r_disty <= w_fl[33:0];
                    r_st <= ST_STEP;
                end
                ST_STEP: begin
                    if ($signed(r_distx) < $signed(r_disty)) begin
                        r_distx <= r_distx + {8'd0, r_sx};
                        r_mx <= n_mx;
                        r_side <= 1'b0;
                        r_ovf <= (n_mx < 0) || (n_mx > 7'sd31);
                    end else begin
                        r_disty <= r_disty + {8'd0, r_sy};
                        r_my <= n_my;
                        r_side <= 1'b1;
                        r_ovf <= (n_my < 0) || (n_my > 7'sd31);
                    end
                    r_steps <= r_steps + 7'd1;
                    r_st <= ST_RD;
                end
                ST_RD: begin
                    r_rd <= r_mem[w_addr];
                    r_st <= r_ovf ? ST_OUT : ST_LOOK;
                    if (r_ovf) begin
                        r_mdata <= 112'd0; r_muser <= 1'b1;
                    end
                end
                ST_LOOK: begin
                    r_code <= r_rd;
                    if (r_rd != 8'd0 && r_rd != r_pass) r_st <= ST_DIV;
                    else if (r_steps == 7'(grdda_pkg::MAX_STEPS)) begin
                        r_mdata <= 112'd0; r_muser <= 1'b1; r_st <= ST_OUT;
                    end else r_st <= ST_STEP;
                end
                ST_DIV: begin
                    r_qneg <= w_neg;
                    r_st <= ST_DWT;
                end
                ST_DWT: begin
                    if (w_rsp.done) begin
                        r_perp <= (w_den == 18'sd0) ? grdda_pkg::PERP_MAX : w_perpc;
                        r_ma <= 23'sd0;
                        r_st <= ST_WALL;
                    end
                end
                ST_WALL: begin
                    r_ma <= r_side ? 23'(r_dx) : 23'(r_dy);
                    r_mb <= $signed({1'b0, r_perp});
                    r_st <= ST_FIN;
                end
                ST_FIN: begin
                    r_frac <= 16'((r_side ? r_px : r_py) + 21'(w_fl[20:0]));
                    r_st <= ST_OUT;
                    r_muser <= 1'b0;
                    r_mdata <= 112'd0;
                end
                ST_OUT: begin
                    if (!r_muser) begin
                        r_mdata <= {1'b0, w_fy, w_fx, r_code - 8'd1, w_tcol, r_frac, w_pb,
                                    r_side, r_my[4:0], r_mx[4:0]};
                    end
                    r_mvalid <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

endmodule

FILE: design/grdda_checker.sv
module grdda_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic o_m_tuser,
    input logic [111:0] o_m_tdata
);
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready) else $error("ready while word pending");
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 112'd0)) else $error("no hit not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata)) else $error("data moved");
endmodule

bind grid_ray_cast_dda grdda_checker u_chk (.*);

FILE: sim/tb_top.sv
module tb_top;

    localparam longint ONE_Q = 65536;
    localparam int STALL_LIMIT = 6000;

    typedef struct {
        logic        miss;
        logic [4:0]  hx;
        logic [4:0]  hy;
        logic        side;
        logic [25:0] pdist;
        logic [15:0] frac;
        logic [5:0]  tcol;
        logic [7:0]  tidx;
        logic [21:0] fx;
        logic [21:0] fy;
    } t_ray_hit;

    class ray_scoreboard;
        logic [7:0] cells [grdda_pkg::MAP_CELLS];
        logic [7:0] pass_code;
        logic [15:0] min_dist;
        t_ray_hit pending_hits [$];
        int errors;

        function new();
            foreach (cells[i]) cells[i] = 8'd0;
            pass_code = 8'd11;
            min_dist = 16'd655;
            errors = 0;
        endfunction

        function longint floor_div(longint v);
            if (v >= 0) return v / ONE_Q;
            return -((-v + ONE_Q - 1) / ONE_Q);
        endfunction

        function longint clamp_dist(longint v);
            if (v < 0) return 0;
            if (v > longint'(grdda_pkg::PERP_MAX)) return longint'(grdda_pkg::PERP_MAX);
            return v;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == grdda_pkg::CFG_PASSABLE) pass_code = val[7:0];
            else min_dist = val;
        endfunction

        // note an accepted input word
        function void note_word(logic kind, logic [151:0] d);
            longint mx, my, px, py, dx, dy, sx, sy, chx, chy, distx, disty;
            longint num, den, perp, wall, frac, tcol, fx, fy;
            int side, n;
            logic hit;
            logic [7:0] code;
            t_ray_hit r;
            mx = longint'(d[4:0]); my = longint'(d[9:5]);
            if (kind == grdda_pkg::KIND_WRITE) begin
                cells[mx * grdda_pkg::MAP_SIZE + my] = d[17:10];
                return;
            end
            px = longint'(d[38:18]); py = longint'(d[59:39]);
            dx = longint'($signed(d[77:60])); dy = longint'($signed(d[95:78]));
            sx = longint'(d[121:96]); sy = longint'(d[147:122]);
            r = '{default: '0};
            side = 0; hit = 0; code = 0;
            if (dx < 0) begin
                chx = -1; distx = floor_div((px - mx * ONE_Q) * sx);
            end else begin
                chx = 1; distx = floor_div((mx * ONE_Q + ONE_Q - px) * sx);
            end
            if (dy < 0) begin
                chy = -1; disty = floor_div((py - my * ONE_Q) * sy);
            end else begin
                chy = 1; disty = floor_div((my * ONE_Q + ONE_Q - py) * sy);
            end
            for (n = 0; n < grdda_pkg::MAX_STEPS; n++) begin
                if (distx < disty) begin
                    distx += sx; mx += chx; side = 0;
                end else begin
                    disty += sy; my += chy; side = 1;
                end
                if (mx < 0 || mx >= grdda_pkg::MAP_SIZE || my < 0 ||
                    my >= grdda_pkg::MAP_SIZE) break;
                code = cells[mx * grdda_pkg::MAP_SIZE + my];
                if (code != 0 && code != pass_code) begin
                    hit = 1;
                    break;
                end
            end
            if (!hit) begin
                r.miss = 1;
                pending_hits.push_back(r);
                return;
            end
            if (side == 0) begin
                num = mx * ONE_Q - px + (chx < 0 ? ONE_Q : 0); den = dx;
            end else begin
                num = my * ONE_Q - py + (chy < 0 ? ONE_Q : 0); den = dy;
            end
            perp = (den == 0) ? longint'(grdda_pkg::PERP_MAX) : clamp_dist((num * ONE_Q) / den);
            wall = (side == 0) ? py + floor_div(perp * dy) : px + floor_div(perp * dx);
            frac = wall & 64'hFFFF;
            if (perp < longint'(min_dist)) perp = clamp_dist(perp + longint'(min_dist));
            tcol = (frac * 64) / ONE_Q;
            if ((side == 0 && dx > 0) || (side == 1 && dy < 0)) tcol = 63 - tcol;
            if (side == 0 && dx > 0) begin
                fx = mx * ONE_Q; fy = my * ONE_Q + frac;
            end else if (side == 0 && dx < 0) begin
                fx = (mx + 1) * ONE_Q; fy = my * ONE_Q + frac;
            end else if (side == 1 && dy > 0) begin
                fx = mx * ONE_Q + frac; fy = my * ONE_Q;
            end else begin
                fx = mx * ONE_Q + frac; fy = (my + 1) * ONE_Q;
            end
            r.hx = 5'(mx); r.hy = 5'(my); r.side = 1'(side); r.pdist = 26'(perp);
            r.frac = 16'(frac); r.tcol = 6'(tcol); r.tidx = code - 8'd1;
            r.fx = 22'(fx); r.fy = 22'(fy);
            pending_hits.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_word(logic [111:0] d, logic miss);
            t_ray_hit e;
            if (pending_hits.size() == 0) begin
                report("unexpected word", longint'(d[63:0]), 0);
                return;
            end
            e = pending_hits.pop_front();
            if (miss !== e.miss) report("no_hit", miss, e.miss);
            if (d[4:0] !== e.hx) report("hit_x", d[4:0], e.hx);
            if (d[9:5] !== e.hy) report("hit_y", d[9:5], e.hy);
            if (d[10] !== e.side) report("side", d[10], e.side);
            if (d[36:11] !== e.pdist) report("perp_dist", d[36:11], e.pdist);
            if (d[52:37] !== e.frac) report("wall_frac", d[52:37], e.frac);
            if (d[58:53] !== e.tcol) report("tex_col", d[58:53], e.tcol);
            if (d[66:59] !== e.tidx) report("tex_index", d[66:59], e.tidx);
            if (d[88:67] !== e.fx) report("floor_x", d[88:67], e.fx);
            if (d[110:89] !== e.fy) report("floor_y", d[110:89], e.fy);
        endtask
    endclass

    logic i_clk, i_rst_n;
    logic i_s_tvalid, o_s_tready, i_s_tuser;
    logic [151:0] i_s_tdata;
    logic o_m_tvalid, i_m_tready, o_m_tuser;
    logic [111:0] o_m_tdata;
    logic i_cfg_we, i_cfg_index;
    logic [15:0] i_cfg_data;

    ray_scoreboard sb;
    int idle_pct;
    int quiet_cycles;

    grid_ray_cast_dda uut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver with random stalls, and the watchdog
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready && i_rst_n) sb.check_word(o_m_tdata, o_m_tuser);
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
        i_m_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic send_word(logic kind, logic [151:0] d);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_word(kind, d);
    endtask

    function automatic logic [151:0] pack_cast(logic [4:0] cx, logic [4:0] cy,
            logic [20:0] px, logic [20:0] py, logic [17:0] dx, logic [17:0] dy,
            logic [25:0] sx, logic [25:0] sy);
        pack_cast = '0;
        pack_cast[9:0] = {cy, cx};
        pack_cast[17:10] = 8'($urandom());
        pack_cast[147:18] = {sy, sx, dy, dx, py, px};
    endfunction

    task automatic write_cell(logic [4:0] cx, logic [4:0] cy, logic [7:0] v);
        logic [151:0] d;
        d = '0;
        d[17:0] = {v, cy, cx};
        d[147:18] = 130'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        send_word(grdda_pkg::KIND_WRITE, d);
    endtask

    function automatic logic [25:0] step_for(logic [17:0] dir);
        longint a;
        a = longint'($signed(dir));
        if (a < 0) a = -a;
        if (a == 0) return grdda_pkg::PERP_MAX;
        a = (ONE_Q * ONE_Q) / a;
        return (a > longint'(grdda_pkg::PERP_MAX)) ? grdda_pkg::PERP_MAX : a[25:0];
    endfunction

    task automatic random_cast();
        logic [4:0] cx, cy;
        logic [20:0] px, py;
        logic [17:0] dx, dy;
        logic [25:0] sx, sy;
        cx = 5'($urandom()); cy = 5'($urandom());
        dx = 18'($urandom()); dy = 18'($urandom());
        if ($urandom_range(9) == 0) dx = 18'($urandom_range(7) - 3);
        if ($urandom_range(9) == 0) dy = 18'($urandom_range(7) - 3);
        if ($urandom_range(9) == 0) begin
            px = 21'($urandom()); py = 21'($urandom());
        end else begin
            px = {cx, 16'(($urandom()))}; py = {cy, 16'(($urandom()))};
        end
        if ($urandom_range(9) == 0) begin
            sx = 26'($urandom()); sy = 26'($urandom());
        end else begin
            sx = step_for(dx); sy = step_for(dy);
        end
        send_word(grdda_pkg::KIND_CAST, pack_cast(cx, cy, px, py, dx, dy, sx, sy));
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_phase(int n_items, int walls);
        logic [7:0] v;
        repeat (walls) write_cell(5'($urandom()), 5'($urandom()), 8'($urandom_range(1, 255)));
        repeat (n_items) begin
            if ($urandom_range(99) < 20) begin
                case ($urandom_range(3))
                    0: v = 8'd0;
                    1: v = sb.pass_code;
                    default: v = 8'($urandom());
                endcase
                write_cell(5'($urandom()), 5'($urandom()), v);
            end else begin
                random_cast();
            end
        end
        drain();
    endtask

    initial begin
        sb = new();
        idle_pct = 29;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = grdda_pkg::CFG_PASSABLE;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: walls, passable cells, edges of the map and the fields
        write_cell(5'd10, 5'd5, 8'd255);
        write_cell(5'd5, 5'd10, 8'd1);
        write_cell(5'd7, 5'd5, 8'd11);
        write_cell(5'd31, 5'd31, 8'd200);
        send_word(grdda_pkg::KIND_CAST, pack_cast(5, 5, {5'd5, 16'h8000}, {5'd5, 16'h8000},
                  18'h10000, 18'h0, 26'h10000, grdda_pkg::PERP_MAX));
        send_word(grdda_pkg::KIND_CAST, pack_cast(5, 5, {5'd5, 16'h0}, {5'd5, 16'hFFFF},
                  18'h0, 18'h10000, grdda_pkg::PERP_MAX, 26'h10000));
        send_word(grdda_pkg::KIND_CAST, pack_cast(5, 5, {5'd5, 16'h1234}, {5'd5, 16'h4321},
                  18'h20000, 18'h1FFFF, 26'h8000, 26'h8000));
        send_word(grdda_pkg::KIND_CAST, pack_cast(0, 0, 21'h0, 21'h0, 18'h30000, 18'h30000,
                  26'h0, 26'h0));
        send_word(grdda_pkg::KIND_CAST, pack_cast(31, 31, 21'h1FFFFF, 21'h1FFFFF, 18'h0,
                  18'h0, 26'h0, 26'h0));
        send_word(grdda_pkg::KIND_CAST, pack_cast(30, 30, {5'd30, 16'h8000},
                  {5'd30, 16'h8000}, 18'h10000, 18'h10000, 26'h10000, 26'h10000));
        send_word(grdda_pkg::KIND_CAST, pack_cast(5, 5, 21'h1FFFFF, 21'h0, 18'h10000, 18'h0,
                  26'h10000, grdda_pkg::PERP_MAX));
        send_word(grdda_pkg::KIND_CAST, pack_cast(9, 5, {5'd9, 16'hFFFF}, {5'd5, 16'h0},
                  18'h1, 18'h3FFFF, 26'h3FFFFFF, 26'h3FFFFFF));
        send_word(grdda_pkg::KIND_CAST, pack_cast(10, 6, {5'd10, 16'h8000}, {5'd6, 16'h8000},
                  18'h0, 18'h3F000, grdda_pkg::PERP_MAX, 26'h11000));
        send_word(grdda_pkg::KIND_CAST, pack_cast(11, 5, {5'd11, 16'h8000}, {5'd5, 16'h8000},
                  18'h30000, 18'h0, 26'h10000, grdda_pkg::PERP_MAX));
        write_cell(5'd10, 5'd5, 8'd0);
        send_word(grdda_pkg::KIND_CAST, pack_cast(5, 5, {5'd5, 16'h8000}, {5'd5, 16'h8000},
                  18'h10000, 18'h0, 26'h10000, grdda_pkg::PERP_MAX));
        drain();

        random_phase(350, 60);
        write_reg(grdda_pkg::CFG_PASSABLE, 16'd0);
        write_reg(grdda_pkg::CFG_MIN_DIST, 16'd0);
        random_phase(300, 60);
        write_reg(grdda_pkg::CFG_PASSABLE, 16'hFF);
        write_reg(grdda_pkg::CFG_MIN_DIST, 16'hFFFF);
        random_phase(300, 60);
        idle_pct = 0;
        write_reg(grdda_pkg::CFG_PASSABLE, 16'($urandom()));
        write_reg(grdda_pkg::CFG_MIN_DIST, 16'($urandom()));
        random_phase(250, 40);
        idle_pct = 29;
        write_reg(grdda_pkg::CFG_PASSABLE, 16'($urandom_range(1, 255)));
        write_reg(grdda_pkg::CFG_MIN_DIST, 16'($urandom_range(0, 4000)));
        random_phase(300, 40);

        if (sb.errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule
